/* rtl/pispd_pkg.sv */
// Package for the PI speed to PWM controller: widths, register indexes,
// reset values and the constant used to divide by one hundred.
// Used by pispd_mul and pi_speed_to_pwm_controller_top; no dependencies.
package pispd_pkg;

    localparam int MEAS_W   = 16;
    localparam int ERR_W    = 18;
    localparam int TGT_W    = 14;
    localparam int GAIN_W   = 8;
    localparam int LIM_W    = 15;
    localparam int PER_W    = 16;
    localparam int DUTY_W   = 7;
    localparam int INT_W    = 16;
    localparam int SUM_W    = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd4;

    localparam logic [TGT_W-1:0]  RST_TARGET_SPEED = 14'd0;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 8'd1;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN     = 8'd1;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT    = 15'd3200;
    localparam logic [PER_W-1:0]  RST_PWM_PERIOD   = 16'd1200;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
    // Division by 32 of the controller output.
    localparam int OUT_SHIFT = 5;

    // ceil(2^30 / 100): exact floor division by 100 for any dividend below 2^23.
    localparam int             RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;
    localparam int             RECIP_SHIFT = 30;
    localparam int             DIVIDEND_W  = 23;

endpackage

/* rtl/pi_speed_to_pwm_controller_top.sv */
// PI speed controller with a clamped integral, giving PWM duty and compare value.
// Depends on pispd_pkg and pispd_mul (the one multiplier shared by every product step).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  meas     | meas_valid / meas_stall   | measured_speed
//  res      | res_valid / res_stall     | duty_percent, compare_value, integral_now
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A transaction runs from ST_MUL_I to ST_DONE: one multiplier, used in turn for the integral
// product, the proportional product, duty times period and the reciprocal step of the
// division by 100, sets the length of the sequence. meas_stall is high while a
// transaction is in progress. A finished result sits in the output register, so a
// new transaction is taken while it waits; the sequence only holds in its last step
// if the previous result has still not been taken. Reset is asynchronous, active low,
// and clears the integral and loads the register defaults. cfg_ready is always high.
module pi_speed_to_pwm_controller_top
    import pispd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        meas_valid,
    output logic                        meas_stall,
    input  logic signed [MEAS_W-1:0]    measured_speed,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic        [DUTY_W-1:0]    duty_percent,
    output logic        [PER_W-1:0]     compare_value,
    output logic signed [INT_W-1:0]     integral_now,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_DAT_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_INTEG,
        ST_MUL_P,
        ST_CTL,
        ST_MUL_C,
        ST_MUL_R,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic        [TGT_W-1:0]    target_reg, target_next;
    logic        [GAIN_W-1:0]   kp_reg, kp_next;
    logic        [GAIN_W-1:0]   ki_reg, ki_next;
    logic        [LIM_W-1:0]    limit_reg, limit_next;
    logic        [PER_W-1:0]    period_reg, period_next;
    logic signed [INT_W-1:0]    sum_reg, sum_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic        [DUTY_W-1:0]   duty_reg, duty_next;
    logic                       res_valid_reg, res_valid_next;
    logic        [DUTY_W-1:0]   res_duty_reg, res_duty_next;
    logic        [PER_W-1:0]    res_cmp_reg, res_cmp_next;
    logic signed [INT_W-1:0]    res_int_reg, res_int_next;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic                       mul_en;

    logic signed [SUM_W-1:0]    integ_full;
    logic signed [SUM_W-1:0]    lim_pos;
    logic signed [SUM_W-1:0]    ctl_full;
    logic signed [SUM_W-1:0]    ctl_div;
    logic                       meas_take;
    logic                       res_take;

    assign meas_take = meas_valid && (state_reg == ST_IDLE);
    assign res_take  = res_valid_reg && !res_stall;

    // The quotient product must survive while the final step waits for the output.
    assign mul_en = (state_reg != ST_DONE);

    pispd_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        case (state_reg)
            ST_MUL_I:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'({1'b0, ki_reg});
            end
            ST_MUL_P:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'({1'b0, kp_reg});
            end
            ST_MUL_C:
            begin
                mul_a = MUL_W'({1'b0, duty_reg});
                mul_b = MUL_W'({1'b0, period_reg});
            end
            ST_MUL_R:
            begin
                mul_a = MUL_W'({1'b0, prod[DIVIDEND_W-1:0]});
                mul_b = MUL_W'({1'b0, RECIP_M});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The products of error and gain fit 25 bits, so truncating prod keeps the signed value.
    assign lim_pos    = SUM_W'({1'b0, limit_reg});
    assign integ_full = SUM_W'(prod) + SUM_W'(sum_reg);
    assign ctl_full   = SUM_W'(prod) + SUM_W'(sum_reg);
    assign ctl_div    = ctl_full >>> OUT_SHIFT;

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        limit_next     = limit_reg;
        period_next    = period_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        duty_next      = duty_reg;
        res_valid_next = res_valid_reg;
        res_duty_next  = res_duty_reg;
        res_cmp_next   = res_cmp_reg;
        res_int_next   = res_int_reg;

        if (res_take)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_SPEED: target_next = cfg_data[TGT_W-1:0];
                REG_PROP_GAIN:    kp_next     = cfg_data[GAIN_W-1:0];
                REG_INT_GAIN:     ki_next     = cfg_data[GAIN_W-1:0];
                REG_INT_LIMIT:    limit_next  = cfg_data[LIM_W-1:0];
                REG_PWM_PERIOD:   period_next = cfg_data[PER_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (meas_take)
                begin
                    err_next   = ERR_W'({target_reg, 1'b0}) - ERR_W'(measured_speed);
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                if (integ_full > lim_pos)
                begin
                    sum_next = INT_W'(lim_pos);
                end
                else if (integ_full < -lim_pos)
                begin
                    sum_next = INT_W'(-lim_pos);
                end
                else
                begin
                    sum_next = INT_W'(integ_full);
                end
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                state_next = ST_CTL;
            end
            ST_CTL:
            begin
                // A negative output, found from the sign bit, clamps to zero duty.
                if (ctl_full[SUM_W-1])
                begin
                    duty_next = '0;
                end
                else if (ctl_div > SUM_W'(DUTY_MAX))
                begin
                    duty_next = DUTY_MAX;
                end
                else
                begin
                    duty_next = ctl_div[DUTY_W-1:0];
                end
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_take)
                begin
                    res_valid_next = 1'b1;
                    res_duty_next  = duty_reg;
                    res_cmp_next   = prod[RECIP_SHIFT +: PER_W];
                    res_int_next   = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= RST_TARGET_SPEED;
            kp_reg        <= RST_PROP_GAIN;
            ki_reg        <= RST_INT_GAIN;
            limit_reg     <= RST_INT_LIMIT;
            period_reg    <= RST_PWM_PERIOD;
            sum_reg       <= '0;
            err_reg       <= '0;
            duty_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_duty_reg  <= '0;
            res_cmp_reg   <= '0;
            res_int_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            limit_reg     <= limit_next;
            period_reg    <= period_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            duty_reg      <= duty_next;
            res_valid_reg <= res_valid_next;
            res_duty_reg  <= res_duty_next;
            res_cmp_reg   <= res_cmp_next;
            res_int_reg   <= res_int_next;
        end
    end

    assign meas_stall    = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign res_valid     = res_valid_reg;
    assign duty_percent  = res_duty_reg;
    assign compare_value = res_cmp_reg;
    assign integral_now  = res_int_reg;

`ifndef SYNTH
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        meas_take |=> meas_stall)
        else $error("controller did not go busy after taking a transaction");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (duty_percent <= DUTY_MAX))
        else $error("duty above maximum");

    a_sum_fits: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg != {1'b1, {(INT_W-1){1'b0}}})
        else $error("integral outside symmetric range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final step");
`endif

endmodule

/* rtl/pispd_mul.sv */
// Shared signed multiplier with a registered product that holds while en is low.
// Depends on pispd_pkg for the operand and product widths.
module pispd_mul
    import pispd_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

/* bench/pi_speed_to_pwm_controller_top_test.sv */
// Self-checking bench for pi_speed_to_pwm_controller_top: drives speed samples and register
// writes, predicts duty, compare value and stored integral, and checks every result.
// Depends on pispd_pkg and the RTL of the controller only.
module pi_speed_to_pwm_controller_top_test
    import pispd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CTL_DIV        = 32;
    localparam int PCT_FULL       = 100;
    localparam int CTRL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 31;
    localparam int MAX_REPORTS    = 40;

    typedef struct {
        logic        [DUTY_W-1:0] duty;
        logic        [PER_W-1:0]  compare;
        logic signed [INT_W-1:0]  integral;
    } pwm_update_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        meas_valid = 1'b0;
    logic                        meas_stall;
    logic signed [MEAS_W-1:0]    measured_speed = '0;
    logic                        res_valid;
    logic                        res_stall = 1'b0;
    logic        [DUTY_W-1:0]    duty_percent;
    logic        [PER_W-1:0]     compare_value;
    logic signed [INT_W-1:0]     integral_now;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index = '0;
    logic        [CFG_DAT_W-1:0] cfg_data = '0;

    // Controller state as the bench expects it to be.
    int tgt_speed = RST_TARGET_SPEED;
    int p_gain    = RST_PROP_GAIN;
    int i_gain    = RST_INT_GAIN;
    int int_limit = RST_INT_LIMIT;
    int pwm_per   = RST_PWM_PERIOD;
    int int_acc   = 0;

    pwm_update_t pending_updates[$];

    int  mismatch_count  = 0;
    int  samples_sent    = 0;
    int  updates_checked = 0;
    int  reg_writes      = 0;
    int  quiet_cycles    = 0;
    bit  tx_idle_on      = 1'b1;
    bit  rx_idle_on      = 1'b1;
    bit  hold_req        = 1'b0;

    pi_speed_to_pwm_controller_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .meas_valid     (meas_valid),
        .meas_stall     (meas_stall),
        .measured_speed (measured_speed),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .duty_percent   (duty_percent),
        .compare_value  (compare_value),
        .integral_now   (integral_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic pwm_update_t predict_pwm_update(input logic signed [MEAS_W-1:0] speed);
        longint err;
        longint acc;
        longint ctl;
        longint duty;
        pwm_update_t upd;
        err = 2 * longint'(tgt_speed) - longint'(speed);
        acc = longint'(int_acc) + err * longint'(i_gain);
        if (acc > int_limit)
            acc = int_limit;
        else if (acc < -int_limit)
            acc = -int_limit;
        int_acc = int'(acc);
        // Signed division truncates towards zero; a negative result gives zero duty, as in the controller.
        ctl = (err * longint'(p_gain) + acc) / CTL_DIV;
        if (ctl > PCT_FULL)
            duty = PCT_FULL;
        else if (ctl < 0)
            duty = 0;
        else
            duty = ctl;
        upd.duty     = DUTY_W'(duty);
        upd.compare  = PER_W'((duty * longint'(pwm_per)) / PCT_FULL);
        upd.integral = INT_W'(acc);
        return upd;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_TARGET_SPEED: tgt_speed = int'(data[TGT_W-1:0]);
            REG_PROP_GAIN:    p_gain    = int'(data[GAIN_W-1:0]);
            REG_INT_GAIN:     i_gain    = int'(data[GAIN_W-1:0]);
            REG_INT_LIMIT:    int_limit = int'(data[LIM_W-1:0]);
            REG_PWM_PERIOD:   pwm_per   = int'(data[PER_W-1:0]);
            default: ;
        endcase
    endfunction

    // Picks a register value with the extremes well represented; the bits above the
    // register width are random so that masking is exercised.
    function automatic logic [CFG_DAT_W-1:0] pick_reg(input int unsigned maxv,
                                                      input int unsigned width);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(99);
        if (r < 15)
            v = 0;
        else if (r < 30)
            v = maxv;
        else
            v = $urandom_range(maxv);
        return CFG_DAT_W'(($urandom << width) | v);
    endfunction

    function automatic logic signed [MEAS_W-1:0] next_speed();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 35)
            v = int'($urandom_range(65535)) - 32768;
        else if (r < 85)
            v = 2 * tgt_speed - (int'($urandom_range(4000)) - 2000);
        else
            v = int'($urandom_range(400)) - 200;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return MEAS_W'(v);
    endfunction

    task automatic send_speed(input logic signed [MEAS_W-1:0] speed);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(12, 1);
        if (gap > 0)
        begin
            meas_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_valid     <= 1'b1;
        measured_speed <= speed;
        @(posedge clk);
        while (meas_stall) @(posedge clk);
        pending_updates.push_back(predict_pwm_update(speed));
        samples_sent++;
    endtask

    // Must be called in the same time step as the last accepted transaction.
    task automatic stop_speed();
        meas_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_updates.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic test_reset_defaults();
        send_speed(16'sd0);
        send_speed(-16'sd1);
        send_speed(-16'sd32768);
        send_speed(16'sd32767);
        send_speed(16'sd1);
        send_speed(-16'sd100);
        stop_speed();
        settle();
    endtask

    // Every register at its top value, written with all data bits set.
    task automatic test_extremes();
        write_reg(REG_TARGET_SPEED, 16'hFFFF);
        write_reg(REG_PROP_GAIN, 16'hFFFF);
        write_reg(REG_INT_GAIN, 16'hFFFF);
        write_reg(REG_INT_LIMIT, 16'hFFFF);
        write_reg(REG_PWM_PERIOD, 16'hFFFF);
        end_writes();
        send_speed(-16'sd32768);
        send_speed(-16'sd32768);
        send_speed(16'sd32767);
        send_speed(16'sd0);
        stop_speed();
        settle();
    endtask

    task automatic test_limit_changes();
        // The integral sits at the top limit; a lower limit must clamp it on the next step.
        write_reg(REG_INT_LIMIT, 16'd100);
        end_writes();
        send_speed(16'sd32767);
        stop_speed();
        settle();
        write_reg(REG_INT_LIMIT, 16'd0);
        write_reg(REG_TARGET_SPEED, 16'd0);
        write_reg(REG_PROP_GAIN, 16'd1);
        write_reg(REG_INT_GAIN, 16'd1);
        end_writes();
        send_speed(-16'sd500);
        send_speed(16'sd500);
        stop_speed();
        settle();
        write_reg(REG_PROP_GAIN, 16'd0);
        write_reg(REG_INT_GAIN, 16'd0);
        end_writes();
        send_speed(-16'sd32768);
        stop_speed();
        settle();
    endtask

    task automatic test_zero_period();
        write_reg(REG_PWM_PERIOD, 16'd0);
        write_reg(REG_TARGET_SPEED, 16'd1000);
        write_reg(REG_PROP_GAIN, 16'd4);
        write_reg(REG_INT_GAIN, 16'd2);
        write_reg(REG_INT_LIMIT, 16'd3200);
        end_writes();
        send_speed(16'sd1900);
        send_speed(-16'sd32768);
        stop_speed();
        settle();
    endtask

    // Writes to indexes beyond the last register must leave every setting alone.
    task automatic test_unknown_index();
        for (int k = int'(REG_PWM_PERIOD) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), 16'hFFFF);
        end_writes();
        send_speed(16'sd1950);
        send_speed(16'sd2100);
        stop_speed();
        settle();
    endtask

    task automatic run_phase(input int count, input int flavour);
        logic [GAIN_W-1:0] gain_top;
        gain_top = ($urandom_range(1)) ? 8'd255 : 8'd16;
        if (flavour == 1)
        begin
            write_reg(REG_TARGET_SPEED, 16'hFFFF);
            write_reg(REG_PROP_GAIN, 16'hFFFF);
            write_reg(REG_INT_GAIN, 16'hFFFF);
            write_reg(REG_INT_LIMIT, 16'hFFFF);
            write_reg(REG_PWM_PERIOD, 16'hFFFF);
        end
        else if (flavour == 2)
        begin
            write_reg(REG_TARGET_SPEED, 16'd0);
            write_reg(REG_PROP_GAIN, 16'd0);
            write_reg(REG_INT_GAIN, 16'd0);
            write_reg(REG_INT_LIMIT, 16'd0);
            write_reg(REG_PWM_PERIOD, 16'd0);
        end
        else
        begin
            write_reg(REG_TARGET_SPEED, pick_reg(2 ** TGT_W - 1, TGT_W));
            write_reg(REG_PROP_GAIN, pick_reg(gain_top, GAIN_W));
            write_reg(REG_INT_GAIN, pick_reg(gain_top, GAIN_W));
            write_reg(REG_INT_LIMIT, pick_reg(2 ** LIM_W - 1, LIM_W));
            write_reg(REG_PWM_PERIOD, pick_reg(2 ** PER_W - 1, PER_W));
            if ($urandom_range(99) < 20)
                write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1,
                                                    int'(REG_PWM_PERIOD) + 1)),
                          CFG_DAT_W'($urandom));
        end
        end_writes();
        repeat (count) send_speed(next_speed());
        stop_speed();
        settle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++)
            run_phase(260, (p == 0) ? 1 : (p == 1) ? 2 : 0);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(200, 0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off for a long while and the sender keeps offering, so the
    // controller fills up and stalls its input.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        run_phase(40, 0);
        tx_idle_on = 1'b1;
    endtask

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on)
                res_stall <= ($urandom_range(99) < IDLE_PCT);
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        pwm_update_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            updates_checked++;
            if (pending_updates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, duty %0d compare %0d integral %0d",
                             $time, duty_percent, compare_value, integral_now);
            end
            else
            begin
                want = pending_updates.pop_front();
                check_field("duty_percent", want.duty, duty_percent);
                check_field("compare_value", want.compare, compare_value);
                check_field("integral_now", want.integral, integral_now);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((meas_valid && !meas_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_updates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_limit_changes();
        test_zero_period();
        test_unknown_index();
        test_random_phases();
        test_no_idle();
        test_backpressure();
        settle();
        repeat (4 * CTRL_CYCLES) @(posedge clk);
        if (pending_updates.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_updates.size());
        end
        $display("Run covered %0d speed samples and %0d register writes; %0d results checked.",
                 samples_sent, reg_writes, updates_checked);
        $display("Phases: register extremes, limit changes, zero period, unused indexes, "
                 , "random settings, no idling and a long receiver hold-off.");
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
